[rtl/krt_pkg.sv]
package krt_pkg;

  // default sizes of the table
  localparam int unsigned TABLE_DEPTH_DEF = 64;
  localparam int unsigned NAME_BYTES_DEF  = 8;

  // request codes
  typedef enum logic [2:0] {
    FN_INSERT   = 3'd0,
    FN_REMOVE   = 3'd1,
    FN_SEL_ID   = 3'd2,
    FN_SEL_NAME = 3'd3,
    FN_UPDATE   = 3'd4,
    FN_LIST     = 3'd5
  } func_e;

  // result status codes
  typedef enum logic [3:0] {
    ST_INSERTED = 4'd0,
    ST_FULL     = 4'd1,
    ST_REMOVED  = 4'd2,
    ST_FOUND    = 4'd3,
    ST_UPDATED  = 4'd4,
    ST_EMPTY    = 4'd5,
    ST_NOTFOUND = 4'd6,
    ST_LISTED   = 4'd7,
    ST_UNKNOWN  = 4'd8
  } status_e;

  // table write source
  typedef enum logic [1:0] {
    WR_NONE   = 2'd0,
    WR_APPEND = 2'd1,
    WR_UPDATE = 2'd2,
    WR_SHIFT  = 2'd3
  } wr_sel_e;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE      = 4'd0,
    S_DISPATCH  = 4'd1,
    S_RD        = 4'd2,
    S_CMP       = 4'd3,
    S_SH_RD     = 4'd4,
    S_SH_WR     = 4'd5,
    S_FOUND     = 4'd6,
    S_EMIT      = 4'd7,
    S_LIST_RD   = 4'd8,
    S_LIST_EMIT = 4'd9
  } ctrl_state_e;

  // request beat
  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] key_id;
    logic [63:0]        name_word;
  } req_t;

  // result beat
  typedef struct packed {
    logic [3:0]         status;
    logic signed [31:0] rec_id;
    logic [63:0]        rec_name;
    logic               last;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic    load_req;
    logic    idx_clr;
    logic    idx_inc;
    logic    ram_re;
    logic    rd_next;
    wr_sel_e wr_sel;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    out_load;
    logic    out_rec;
    logic    out_last;
    status_e out_status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] func;
    logic       cnt_zero;
    logic       cnt_full;
    logic       idx_last;
    logic       nxt_last;
    logic       id_match;
    logic       name_match;
    logic       out_free;
  } sts_t;

endpackage

[rtl/krt_ram.sv]
module krt_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/krt_ctrl.sv]
module krt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  krt_pkg::sts_t sts_i,
  output krt_pkg::cmd_t cmd_o
);

  krt_pkg::ctrl_state_e state_q, state_d;
  krt_pkg::status_e     st_q, st_d;
  logic                 hit;

  // match on name for select by name, on id otherwise
  assign hit = (sts_i.func == krt_pkg::FN_SEL_NAME) ? sts_i.name_match : sts_i.id_match;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= krt_pkg::S_IDLE;
      st_q    <= krt_pkg::ST_UNKNOWN;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      krt_pkg::S_IDLE: begin
        if (in_valid_i) state_d = krt_pkg::S_DISPATCH;
      end
      krt_pkg::S_DISPATCH: begin
        case (sts_i.func)
          krt_pkg::FN_INSERT: state_d = krt_pkg::S_EMIT;
          krt_pkg::FN_REMOVE, krt_pkg::FN_SEL_ID, krt_pkg::FN_SEL_NAME,
          krt_pkg::FN_UPDATE: state_d = sts_i.cnt_zero ? krt_pkg::S_EMIT : krt_pkg::S_RD;
          krt_pkg::FN_LIST:   state_d = sts_i.cnt_zero ? krt_pkg::S_EMIT : krt_pkg::S_LIST_RD;
          default:            state_d = krt_pkg::S_EMIT;
        endcase
      end
      krt_pkg::S_RD: state_d = krt_pkg::S_CMP;
      krt_pkg::S_CMP: begin
        if (hit) begin
          case (sts_i.func)
            krt_pkg::FN_UPDATE: state_d = krt_pkg::S_EMIT;
            krt_pkg::FN_REMOVE: state_d = sts_i.idx_last ? krt_pkg::S_EMIT : krt_pkg::S_SH_RD;
            default:            state_d = krt_pkg::S_FOUND;
          endcase
        end else begin
          state_d = sts_i.idx_last ? krt_pkg::S_EMIT : krt_pkg::S_RD;
        end
      end
      krt_pkg::S_SH_RD: state_d = krt_pkg::S_SH_WR;
      krt_pkg::S_SH_WR: state_d = sts_i.nxt_last ? krt_pkg::S_EMIT : krt_pkg::S_SH_RD;
      krt_pkg::S_FOUND, krt_pkg::S_EMIT: begin
        if (sts_i.out_free) state_d = krt_pkg::S_IDLE;
      end
      krt_pkg::S_LIST_RD: state_d = krt_pkg::S_LIST_EMIT;
      krt_pkg::S_LIST_EMIT: begin
        if (sts_i.out_free) state_d = sts_i.idx_last ? krt_pkg::S_IDLE : krt_pkg::S_LIST_RD;
      end
      default: state_d = krt_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o            = '0;
    cmd_o.wr_sel     = krt_pkg::WR_NONE;
    cmd_o.out_status = krt_pkg::ST_UNKNOWN;
    in_ready_o       = 1'b0;
    st_d             = st_q;
    case (state_q)
      krt_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          cmd_o.idx_clr  = 1'b1;
        end
      end
      krt_pkg::S_DISPATCH: begin
        case (sts_i.func)
          krt_pkg::FN_INSERT: begin
            if (sts_i.cnt_full) begin
              st_d = krt_pkg::ST_FULL;
            end else begin
              cmd_o.wr_sel  = krt_pkg::WR_APPEND;
              cmd_o.cnt_inc = 1'b1;
              st_d          = krt_pkg::ST_INSERTED;
            end
          end
          krt_pkg::FN_REMOVE, krt_pkg::FN_SEL_ID, krt_pkg::FN_SEL_NAME,
          krt_pkg::FN_LIST: st_d = krt_pkg::ST_EMPTY;
          krt_pkg::FN_UPDATE: st_d = krt_pkg::ST_NOTFOUND;
          default:            st_d = krt_pkg::ST_UNKNOWN;
        endcase
      end
      krt_pkg::S_RD: cmd_o.ram_re = 1'b1;
      krt_pkg::S_CMP: begin
        if (hit) begin
          case (sts_i.func)
            krt_pkg::FN_UPDATE: begin
              cmd_o.wr_sel = krt_pkg::WR_UPDATE;
              st_d         = krt_pkg::ST_UPDATED;
            end
            krt_pkg::FN_REMOVE: begin
              st_d = krt_pkg::ST_REMOVED;
              if (sts_i.idx_last) cmd_o.cnt_dec = 1'b1;
            end
            default: st_d = krt_pkg::ST_FOUND;
          endcase
        end else if (sts_i.idx_last) begin
          st_d = krt_pkg::ST_NOTFOUND;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      krt_pkg::S_SH_RD: begin
        cmd_o.ram_re  = 1'b1;
        cmd_o.rd_next = 1'b1;
      end
      // move the next entry down one slot
      krt_pkg::S_SH_WR: begin
        cmd_o.wr_sel  = krt_pkg::WR_SHIFT;
        cmd_o.idx_inc = 1'b1;
        if (sts_i.nxt_last) cmd_o.cnt_dec = 1'b1;
      end
      krt_pkg::S_FOUND: begin
        if (sts_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_rec    = 1'b1;
          cmd_o.out_last   = 1'b1;
          cmd_o.out_status = krt_pkg::ST_FOUND;
        end
      end
      krt_pkg::S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_last   = 1'b1;
          cmd_o.out_status = st_q;
        end
      end
      krt_pkg::S_LIST_RD: cmd_o.ram_re = 1'b1;
      krt_pkg::S_LIST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_rec    = 1'b1;
          cmd_o.out_last   = sts_i.idx_last;
          cmd_o.out_status = krt_pkg::ST_LISTED;
          cmd_o.idx_inc    = !sts_i.idx_last;
        end
      end
      default: ;
    endcase
  end

endmodule

[rtl/krt_dp.sv]
module krt_dp #(
  parameter int unsigned TABLE_DEPTH = krt_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned NAME_BYTES  = krt_pkg::NAME_BYTES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  krt_pkg::req_t in_i,
  input  krt_pkg::cmd_t cmd_i,
  output krt_pkg::sts_t sts_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output krt_pkg::res_t out_o
);

  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned XW = CW + 1;
  localparam int unsigned NW = 8 * NAME_BYTES;
  localparam int unsigned RW = 32 + NW;

  logic [2:0]    func_q;
  logic [31:0]   key_q;
  logic [NW-1:0] name_q;
  logic [NW-1:0] name_c;
  logic [IW-1:0] idx_q, idx_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;
  krt_pkg::res_t out_q;
  logic          alive;

  logic          ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [RW-1:0] ram_wdata, ram_rdata;
  logic [31:0]   rd_id;
  logic [NW-1:0] rd_name;

  // canonical name: first bytes up to the first zero byte
  always_comb begin
    name_c = '0;
    alive  = 1'b1;
    for (int k = 0; k < NAME_BYTES; k++) begin
      if (in_i.name_word[8*k +: 8] == 8'd0) alive = 1'b0;
      if (alive) name_c[8*k +: 8] = in_i.name_word[8*k +: 8];
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      func_q <= in_i.func;
      key_q  <= in_i.key_id;
      name_q <= name_c;
    end
  end

  // slot index and entry count
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_clr)      idx_d = '0;
    else if (cmd_i.idx_inc) idx_d = idx_q + 1'b1;
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc)      cnt_d = cnt_q + 1'b1;
    else if (cmd_i.cnt_dec) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      cnt_q <= '0;
    end else begin
      idx_q <= idx_d;
      cnt_q <= cnt_d;
    end
  end

  // table write and read addressing
  always_comb begin
    ram_we    = 1'b1;
    ram_waddr = idx_q;
    ram_wdata = {key_q, name_q};
    case (cmd_i.wr_sel)
      krt_pkg::WR_APPEND: ram_waddr = cnt_q[IW-1:0];
      krt_pkg::WR_UPDATE: ram_waddr = idx_q;
      krt_pkg::WR_SHIFT:  ram_wdata = ram_rdata;
      default:            ram_we    = 1'b0;
    endcase
    ram_raddr = cmd_i.rd_next ? IW'(idx_q + 1'b1) : idx_q;
  end

  krt_ram #(
    .WIDTH (RW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_id   = ram_rdata[RW-1 -: 32];
  assign rd_name = ram_rdata[NW-1:0];

  // status toward the controller
  always_comb begin
    sts_o.func       = func_q;
    sts_o.cnt_zero   = (cnt_q == '0);
    sts_o.cnt_full   = (cnt_q == CW'(TABLE_DEPTH));
    sts_o.idx_last   = ((XW'(idx_q) + XW'(1)) == XW'(cnt_q));
    sts_o.nxt_last   = ((XW'(idx_q) + XW'(2)) == XW'(cnt_q));
    sts_o.id_match   = (rd_id == key_q);
    sts_o.name_match = (rd_name == name_q);
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  // result register
  assign out_valid_d = cmd_i.out_load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.status   <= cmd_i.out_status;
      out_q.rec_id   <= cmd_i.out_rec ? rd_id : key_q;
      out_q.rec_name <= cmd_i.out_rec ? 64'(rd_name) : 64'd0;
      out_q.last     <= cmd_i.out_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

[rtl/keyed_record_table_top.sv]
// keyed record table: an unsorted, compacted table of id and name records
//
// request channel (in_valid_i, in_ready_o, in_i) carries one beat
// per request: func, key_id and name_word. result channel (out_valid_o,
// out_ready_i, out_o) carries status, rec_id, rec_name and last. list gives
// one result beat per entry (a single beat on an empty table), every other request gives exactly one beat.
//
// one request is worked at a time; in_ready_o is high only while idle.
// the table memory has separate write and read ports and a registered read.
// insert, unknown requests and requests on an empty table go from dispatch
// straight to the result; a search reads and compares one slot at a time,
// a remove then moves each later entry down one slot, and list reads and
// emits one entry at a time.
//
// reset clears the entry count and the controller, so the table starts empty;
// the memory itself is not cleared. results pass through an output register,
// so a new request is taken while the last result still waits; when the
// receiver stalls, work stops at the next result beat until it is taken.
module keyed_record_table_top #(
  parameter int unsigned TABLE_DEPTH = krt_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned NAME_BYTES  = krt_pkg::NAME_BYTES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  krt_pkg::req_t in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output krt_pkg::res_t out_o
);

  krt_pkg::cmd_t cmd;
  krt_pkg::sts_t sts;

  krt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  krt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .NAME_BYTES  (NAME_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

[rtl/krt_checker.sv]
module krt_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_i,
  input krt_pkg::req_t in_i,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input krt_pkg::res_t out_i
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_i)))
    else $error("result beat changed while stalled");

  // one request at a time: busy right after a request beat
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("request taken while previous one in progress");

  // only list entries can be non-final
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (out_i.status != krt_pkg::ST_LISTED)) |-> out_i.last)
    else $error("non-list result without last");

  // name is zero unless a record is returned
  a_name: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (out_i.status != krt_pkg::ST_LISTED)
     && (out_i.status != krt_pkg::ST_FOUND)) |-> (out_i.rec_name == 64'd0))
    else $error("name on a result without record");

endmodule

bind keyed_record_table_top krt_checker u_krt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .in_i        (in_i),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_i       (out_o)
);

[tb/sv/keyed_record_table_checker.sv]
module keyed_record_table_checker
  import krt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned NAME_BYTES  = NAME_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  req_t        in_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  res_t        out_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_o
);

  localparam int unsigned MAX_PRINTS = 40;

  // shadow copy of the table
  logic [31:0] slot_id   [TABLE_DEPTH];
  logic [63:0] slot_name [TABLE_DEPTH];
  int          fill_count = 0;

  // results still owed by the block, oldest first
  res_t        owed_results [$];
  int unsigned mismatch_total = 0;
  int unsigned owed_total = 0;

  assign mismatch_count_o = mismatch_total;
  assign pending_o        = owed_total;

  task automatic report_mismatch(input string what);
    if (mismatch_total < MAX_PRINTS) begin
      $display("krt check @%0t: %s", $time, what);
    end
    mismatch_total++;
  endtask

  // lowest slot holding this id, -1 if none
  function automatic int first_id_slot(input logic [31:0] id);
    for (int i = 0; i < fill_count; i++) begin
      if (slot_id[i] == id) return i;
    end
    return -1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t        want;
    res_t        entry;
    int          slot;
    logic [63:0] nm;
    bit          stop;

    if (!rst_ni) begin
      owed_results.delete();
      fill_count = 0;
      owed_total <= 0;
    end else begin
      // result beat against the oldest owed result
      if (out_valid_i && out_ready_i) begin
        if (owed_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing owed: status %0d id %0d name %h",
                                    out_i.status, out_i.rec_id, out_i.rec_name));
        end else begin
          want = owed_results.pop_front();
          if (out_i.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d (id %0d)",
                                      out_i.status, want.status, want.rec_id));
          if (out_i.rec_id !== want.rec_id)
            report_mismatch($sformatf("rec_id %0d, want %0d", out_i.rec_id, want.rec_id));
          if (out_i.rec_name !== want.rec_name)
            report_mismatch($sformatf("rec_name %h, want %h (id %0d)",
                                      out_i.rec_name, want.rec_name, want.rec_id));
          if (out_i.last !== want.last)
            report_mismatch($sformatf("last %b, want %b (id %0d)",
                                      out_i.last, want.last, want.rec_id));
        end
      end

      // request beat: work out its results and update the shadow table
      if (in_valid_i && in_ready_i) begin
        // canonical name: first NAME_BYTES bytes, cut at the first zero byte
        nm   = '0;
        stop = 1'b0;
        for (int k = 0; k < 8; k++) begin
          if (k >= NAME_BYTES || in_i.name_word[8*k +: 8] == 8'h00) stop = 1'b1;
          if (!stop) nm[8*k +: 8] = in_i.name_word[8*k +: 8];
        end

        entry.status   = ST_UNKNOWN;
        entry.rec_id   = in_i.key_id;
        entry.rec_name = '0;
        entry.last     = 1'b1;

        case (in_i.func)
          FN_INSERT: begin
            if (fill_count >= TABLE_DEPTH) begin
              entry.status = ST_FULL;
            end else begin
              slot_id[fill_count]   = in_i.key_id;
              slot_name[fill_count] = nm;
              fill_count++;
              entry.status = ST_INSERTED;
            end
            owed_results.push_back(entry);
          end
          FN_REMOVE: begin
            slot = first_id_slot(in_i.key_id);
            if (slot >= 0) begin
              // compact: later entries move down one slot
              for (int i = slot; i + 1 < fill_count; i++) begin
                slot_id[i]   = slot_id[i+1];
                slot_name[i] = slot_name[i+1];
              end
              fill_count--;
              entry.status = ST_REMOVED;
            end else begin
              entry.status = (fill_count == 0) ? ST_EMPTY : ST_NOTFOUND;
            end
            owed_results.push_back(entry);
          end
          FN_SEL_ID: begin
            slot = first_id_slot(in_i.key_id);
            if (slot >= 0) begin
              entry.status   = ST_FOUND;
              entry.rec_id   = slot_id[slot];
              entry.rec_name = slot_name[slot];
            end else begin
              entry.status = (fill_count == 0) ? ST_EMPTY : ST_NOTFOUND;
            end
            owed_results.push_back(entry);
          end
          FN_SEL_NAME: begin
            slot = -1;
            for (int i = 0; i < fill_count && slot < 0; i++) begin
              if (slot_name[i] == nm) slot = i;
            end
            if (slot >= 0) begin
              entry.status   = ST_FOUND;
              entry.rec_id   = slot_id[slot];
              entry.rec_name = slot_name[slot];
            end else begin
              entry.status = (fill_count == 0) ? ST_EMPTY : ST_NOTFOUND;
            end
            owed_results.push_back(entry);
          end
          FN_UPDATE: begin
            // an empty table reports not found here, not empty
            slot = first_id_slot(in_i.key_id);
            if (slot >= 0) begin
              slot_name[slot] = nm;
              entry.status    = ST_UPDATED;
            end else begin
              entry.status = ST_NOTFOUND;
            end
            owed_results.push_back(entry);
          end
          FN_LIST: begin
            if (fill_count == 0) begin
              entry.status = ST_EMPTY;
              owed_results.push_back(entry);
            end else begin
              for (int i = 0; i < fill_count; i++) begin
                entry.status   = ST_LISTED;
                entry.rec_id   = slot_id[i];
                entry.rec_name = slot_name[i];
                entry.last     = (i + 1 == fill_count);
                owed_results.push_back(entry);
              end
            end
          end
          default: begin
            owed_results.push_back(entry);
          end
        endcase
      end

      owed_total <= owed_results.size();
    end
  end

endmodule

[tb/sv/keyed_record_table_top_tb.sv]
module keyed_record_table_top_tb;
  import krt_pkg::*;

  // request codes the block does not know
  localparam logic [2:0] FN_RSVD_LO = 3'd6;
  localparam logic [2:0] FN_RSVD_HI = 3'd7;

  localparam int unsigned ID_POOL       = 12;
  localparam int unsigned NAME_POOL     = 10;
  localparam int unsigned SEGMENTS      = 8;
  localparam int unsigned SETTLE_CYCLES = 150;
  localparam longint unsigned RUN_LIMIT = 64'd6_000_000;

  typedef enum int {SEG_MIXED, SEG_FILL, SEG_DRAIN} seg_kind_e;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  req_t        in_beat   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  res_t        out_beat;
  bit          gaps_on   = 1'b1;
  int unsigned mismatch_count;
  int unsigned owed_count;

  logic [31:0] id_pool   [ID_POOL];
  logic [63:0] name_pool [NAME_POOL];
  int unsigned name_len  [NAME_POOL];
  seg_kind_e   seg_plan  [SEGMENTS] = '{SEG_MIXED, SEG_FILL, SEG_DRAIN, SEG_MIXED,
                                        SEG_FILL, SEG_MIXED, SEG_DRAIN, SEG_MIXED};

  always #1 clk = ~clk;

  keyed_record_table_top dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_i       (in_beat),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_o      (out_beat)
  );

  keyed_record_table_checker krt_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .in_i            (in_beat),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .out_i           (out_beat),
    .mismatch_count_o(mismatch_count),
    .pending_o       (owed_count)
  );

  // one request beat, with an optional gap before it
  task automatic send_request(input logic [2:0] f, input logic [31:0] k,
                              input logic [63:0] n);
    req_t beat;
    beat.func      = f;
    beat.key_id    = k;
    beat.name_word = n;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= beat;
    do @(posedge clk); while (!in_ready);
  endtask

  // mostly known ids so searches hit, sometimes anything
  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 99) < 80) return id_pool[$urandom_range(0, ID_POOL - 1)];
    return $urandom;
  endfunction

  // pool names with junk after the terminator, or a raw random word
  function automatic logic [63:0] pick_name();
    int unsigned j;
    logic [63:0] w;
    if ($urandom_range(0, 4) == 0) return {$urandom, $urandom};
    j = $urandom_range(0, NAME_POOL - 1);
    w = name_pool[j];
    if (name_len[j] < 8 && $urandom_range(0, 1) == 1)
      w = w | ({$urandom, $urandom} << (8 * (name_len[j] + 1)));
    return w;
  endfunction

  // request mix per segment kind
  function automatic logic [2:0] pick_func(input seg_kind_e kind);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (kind == SEG_FILL && r < 85) return FN_INSERT;
    if (kind == SEG_DRAIN && r < 65) return FN_REMOVE;
    r = $urandom_range(0, 99);
    if (r < 22) return FN_INSERT;
    if (r < 37) return FN_REMOVE;
    if (r < 52) return FN_SEL_ID;
    if (r < 67) return FN_SEL_NAME;
    if (r < 80) return FN_UPDATE;
    if (r < 92) return FN_LIST;
    if (r < 96) return FN_RSVD_LO;
    return FN_RSVD_HI;
  endfunction

  // result side: random stall bursts
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (gaps_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // hard stop
  initial begin
    #(RUN_LIMIT);
    $display("keyed_record_table_top_tb: done, errors");
    $finish;
  end

  // stimulus and verdict
  initial begin
    int unsigned seg_items;
    logic [63:0] w;

    // pools: extremes plus random ids, names of every length
    id_pool[0] = 32'h8000_0000;
    id_pool[1] = 32'h7fff_ffff;
    id_pool[2] = 32'h0000_0000;
    id_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < ID_POOL; i++) id_pool[i] = $urandom;
    for (int j = 0; j < NAME_POOL; j++) begin
      name_len[j] = (j < 9) ? j : $urandom_range(0, 8);
      w = '0;
      for (int b = 0; b < name_len[j]; b++) w[8*b +: 8] = $urandom_range(1, 255);
      name_pool[j] = w;
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table on every request kind but insert, one reserved code only
    send_request(FN_LIST,     32'd0,        64'd0);
    send_request(FN_REMOVE,   32'd5,        64'd0);
    send_request(FN_SEL_ID,   32'd5,        64'd0);
    send_request(FN_SEL_NAME, 32'd5,        64'h0000_0000_0041_4243);
    send_request(FN_UPDATE,   32'd5,        64'h0000_0000_0000_0058);
    send_request(FN_RSVD_LO,  32'h1234_5678, 64'hffff_ffff_ffff_ffff);
    // extremes, empty name, name cut by a zero byte, duplicate id
    send_request(FN_INSERT,   32'h8000_0000, 64'hffff_ffff_ffff_ffff);
    send_request(FN_INSERT,   32'h7fff_ffff, 64'h0000_0000_0000_0000);
    send_request(FN_INSERT,   32'h7fff_ffff, 64'h1122_3300_4455_6677);
    // first match wins, name compare on canonical form
    send_request(FN_SEL_ID,   32'h7fff_ffff, 64'd0);
    send_request(FN_SEL_NAME, 32'd9,        64'hdead_be00_4455_6677);
    send_request(FN_SEL_NAME, 32'd9,        64'h0000_0000_0000_0000);
    send_request(FN_SEL_NAME, 32'd9,        64'h0102_0304_0506_0708);
    send_request(FN_UPDATE,   32'h7fff_ffff, 64'h00ff_ffff_ffff_ffff);
    send_request(FN_SEL_ID,   32'h8000_0000, 64'd0);
    send_request(FN_LIST,     32'd0,        64'd0);
    // remove the first duplicate, then miss
    send_request(FN_REMOVE,   32'h7fff_ffff, 64'd0);
    send_request(FN_REMOVE,   32'h1234_5678, 64'd0);
    send_request(FN_RSVD_HI,  32'hffff_ffff, 64'd0);
    send_request(FN_SEL_ID,   32'h7fff_ffff, 64'd0);
    send_request(FN_LIST,     32'd0,        64'd0);
    send_request(FN_REMOVE,   32'h8000_0000, 64'd0);
    send_request(FN_REMOVE,   32'h7fff_ffff, 64'd0);
    send_request(FN_LIST,     32'd0,        64'd0);

    // random segments: fill to full, drain, mixed traffic
    for (int s = 0; s < SEGMENTS; s++) begin
      gaps_on   = (s + 1 < SEGMENTS) ? ($urandom_range(0, 3) != 0) : 1'b0;
      seg_items = (seg_plan[s] == SEG_FILL) ? 90 : (seg_plan[s] == SEG_DRAIN) ? 80 : 45;
      for (int n = 0; n < seg_items; n++) begin
        send_request(pick_func(seg_plan[s]), pick_key(), pick_name());
      end
    end

    // drain everything owed, then watch for strays
    in_valid <= 1'b0;
    @(posedge clk);
    while (owed_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("keyed_record_table_top_tb: done, clean");
    end else begin
      $display("keyed_record_table_top_tb: done, errors");
    end
    $finish;
  end

endmodule
